FILE: rtl/page_first_fit_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// page first-fit allocator assertion macros
// property wrappers used by the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef PAGE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define PFFA_ASSERT_NOW(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pffa check failed");
`define PFFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pffa check failed");
`else
`define PFFA_ASSERT_NOW(name, cond)
`define PFFA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/pffa_pkg.sv
// ---------------------------------------------------------------------------
// page first-fit allocator package
// sizes, controller states and the command and status bundles
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pffa_pkg;

  localparam int MAX_PAGES   = 64;
  localparam int QW_PER_PAGE = 256;
  localparam int PAGE_W      = $clog2(MAX_PAGES);
  localparam int CNT_W       = $clog2(MAX_PAGES + 1);
  localparam int QW_W        = 9;
  localparam int OFFS_W      = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic chk_valid;
    logic fit;
    logic last;
  } status_t;

endpackage

FILE: rtl/pffa_if.sv
// ---------------------------------------------------------------------------
// page first-fit allocator channels
// request and result handshake bundles
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pffa_req_if;
  logic       valid;
  logic       ready;
  logic [8:0] quad_words;

  modport source (output valid, output quad_words, input ready);
  modport sink (input valid, input quad_words, output ready);
endinterface

interface pffa_rsp_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [5:0]  page_index;
  logic [8:0]  first_quad_word;
  logic [18:0] byte_offset;

  modport source (output valid, output granted, output page_index,
                  output first_quad_word, output byte_offset, input ready);
  modport sink (input valid, input granted, input page_index,
                input first_quad_word, input byte_offset, output ready);
endinterface

FILE: rtl/page_first_fit_allocator_core.sv
// ---------------------------------------------------------------------------
// page first-fit allocator core
// first-fit quadword allocation over up to 64 pages of 256 quadwords
// ---------------------------------------------------------------------------
// One request is handled at a time. The scan walks the pages from page 0
// and stops at the first page that fits or after the last page; a page
// count of zero fails at acceptance without a scan. The free-count memory
// has one read port, so the scan checks one page per cycle. The next
// request is taken once the result has been handed off.
// Page counts are full (256) after reset with no clearing pass.
`timescale 1ns / 1ps

`include "page_first_fit_allocator_core_defines.svh"

module page_first_fit_allocator_core
  import pffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  pffa_req_if.sink         req,
  pffa_rsp_if.source       rsp
);

  cmd_t    cmd;
  status_t st;

  pffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pffa_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_quad_words       (req.quad_words),
    .cmd                 (cmd),
    .st                  (st),
    .res_granted         (rsp.granted),
    .res_page_index      (rsp.page_index),
    .res_first_quad_word (rsp.first_quad_word),
    .res_byte_offset     (rsp.byte_offset)
  );

  `PFFA_ASSERT_NOW(a_no_overlap, !(req.ready && rsp.valid))
  `PFFA_ASSERT_NOW(a_commit_fits, !cmd.commit || (st.chk_valid && st.fit))
  `PFFA_ASSERT_NEXT(a_commit_resp, cmd.commit, rsp.valid && rsp.granted)
  `PFFA_ASSERT_NOW(a_fail_zero, !(rsp.valid && !rsp.granted) || (rsp.page_index == '0 && rsp.first_quad_word == '0 && rsp.byte_offset == '0))

endmodule

FILE: rtl/pffa_ctrl.sv
// ---------------------------------------------------------------------------
// page first-fit allocator controller
// sequences accept, page scan and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pffa_ctrl
  import pffa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = st.limit_zero ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.chk_valid && (st.fit || st.last)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        cmd.fail  = in_valid && st.limit_zero;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.commit = st.chk_valid && st.fit;
        cmd.fail   = st.chk_valid && !st.fit && st.last;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/pffa_dp.sv
// ---------------------------------------------------------------------------
// page first-fit allocator datapath
// free-count memory, scan pointer, fit compare and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pffa_dp
  import pffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic [QW_W-1:0]   in_quad_words,
  input  cmd_t              cmd,
  output status_t           st,
  output logic              res_granted,
  output logic [PAGE_W-1:0] res_page_index,
  output logic [QW_W-1:0]   res_first_quad_word,
  output logic [OFFS_W-1:0] res_byte_offset
);

  logic [QW_W-1:0]      free_mem [MAX_PAGES];
  logic [MAX_PAGES-1:0] written;

  logic [CNT_W-1:0]  page_count;
  logic [CNT_W-1:0]  limit;
  logic [QW_W-1:0]   size;
  logic [CNT_W-1:0]  rd_ptr;
  logic [PAGE_W-1:0] chk_ptr;
  logic              chk_valid;
  logic [QW_W-1:0]   rd_data;
  logic              rd_written;

  logic              issue;
  logic [QW_W-1:0]   avail;
  logic [QW_W-1:0]   first;
  logic [CNT_W-1:0]  limit_next;

  assign issue      = cmd.scan && (rd_ptr < limit);
  assign avail      = rd_written ? rd_data : QW_W'(QW_PER_PAGE);
  assign first      = QW_W'(QW_PER_PAGE) - avail;
  assign limit_next = (page_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count;

  assign st.limit_zero = (page_count == '0);
  assign st.chk_valid  = chk_valid;
  assign st.fit        = (avail >= size);
  assign st.last       = ((CNT_W'(chk_ptr) + CNT_W'(1)) == limit);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= CNT_W'(MAX_PAGES);
    end else if (cfg_wr_en) begin
      page_count <= cfg_wr_data;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      rd_ptr    <= '0;
    end else if (cmd.start) begin
      chk_valid <= 1'b0;
      rd_ptr    <= '0;
    end else begin
      chk_valid <= issue;
      if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size  <= in_quad_words;
      limit <= limit_next;
    end
    if (issue) begin
      chk_ptr <= rd_ptr[PAGE_W-1:0];
    end
  end

  // entries never written read as a full page
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.commit) begin
      written[chk_ptr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_written <= written[rd_ptr[PAGE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      free_mem[chk_ptr] <= avail - size;
    end
    if (issue) begin
      rd_data <= free_mem[rd_ptr[PAGE_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_granted         <= 1'b1;
      res_page_index      <= chk_ptr;
      res_first_quad_word <= first;
      res_byte_offset     <= {1'b0, chk_ptr, 12'b0} + {6'b0, first, 4'b0};
    end else if (cmd.fail) begin
      res_granted         <= 1'b0;
      res_page_index      <= '0;
      res_first_quad_word <= '0;
      res_byte_offset     <= '0;
    end
  end

endmodule
